// File: design/salc_pkg.sv
// Shared package for the set-associative LRU cache tag block.
// Holds default geometry, the controller state type, the command and status
// structs, and an elaboration-time log2 helper. No dependencies.
package salc_pkg;

  localparam int unsigned DEF_BLOCK_BYTES = 64;
  localparam int unsigned DEF_CACHE_BYTES = 32768;
  localparam int unsigned DEF_WAYS        = 4;
  localparam int unsigned DEF_ADDR_BITS   = 32;

  // Fixed widths of the item fields.
  localparam int unsigned IN_ADDR_W  = 32;
  localparam int unsigned OUT_ADDR_W = 32;
  localparam int unsigned OUT_WAY_W  = 2;
  localparam int unsigned CNT_W      = 64;
  localparam int unsigned WORD_W     = 64;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } salc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;   // write the reset row at the sweep pointer
    logic capture;  // latch the address and read its set row
    logic update;   // resolve the lookup, write the row back, emit the result
  } salc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last; // sweep pointer is at the last set
  } salc_sts_t;

  function automatic int unsigned flog2(input int unsigned v);
    int unsigned n;
    int unsigned x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

// File: design/salc_ctrl.sv
// Controller state machine for the set-associative LRU cache tag block.
// Sequences the clearing sweep, item acceptance and the lookup/update state.
// Depends on salc_pkg.
module salc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  salc_pkg::salc_sts_t     sts,
  output logic                    busy,
  output salc_pkg::salc_cmd_t     cmd
);

  salc_pkg::salc_state_t state_r;
  salc_pkg::salc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= salc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    busy        = 1'b1;
    unique case (state_r)
      salc_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = salc_pkg::ST_IDLE;
        end
      end
      salc_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
        if (start) begin
          state_nxt = salc_pkg::ST_LOOKUP;
        end
      end
      salc_pkg::ST_LOOKUP: begin
        cmd.update = 1'b1;
        state_nxt  = salc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = salc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// File: design/salc_dpath.sv
// Datapath for the set-associative LRU cache tag block: set-row memory,
// tag compare, victim choice, age update, counters and result registers.
// Depends on salc_pkg; driven by salc_ctrl commands.
module salc_dpath #(
  parameter int unsigned BLOCK_BYTES = salc_pkg::DEF_BLOCK_BYTES,
  parameter int unsigned CACHE_BYTES = salc_pkg::DEF_CACHE_BYTES,
  parameter int unsigned WAYS        = salc_pkg::DEF_WAYS,
  parameter int unsigned ADDR_BITS   = salc_pkg::DEF_ADDR_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  salc_pkg::salc_cmd_t               cmd,
  output salc_pkg::salc_sts_t               sts,
  input  logic [salc_pkg::IN_ADDR_W-1:0]    in_address,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [salc_pkg::OUT_WAY_W-1:0]    out_way,
  output logic                              out_evicted,
  output logic                              out_writeback_valid,
  output logic [salc_pkg::OUT_ADDR_W-1:0]   out_writeback_address,
  output logic [salc_pkg::CNT_W-1:0]        out_request_count,
  output logic [salc_pkg::CNT_W-1:0]        out_hit_count,
  output logic [salc_pkg::CNT_W-1:0]        out_miss_count,
  output logic [salc_pkg::CNT_W-1:0]        out_eviction_count
);

  localparam int unsigned OBITS     = salc_pkg::flog2(BLOCK_BYTES);
  localparam int unsigned NSETS_RAW = CACHE_BYTES / (BLOCK_BYTES * WAYS);
  localparam int unsigned NSETS     = (NSETS_RAW > 0) ? NSETS_RAW : 1;
  localparam int unsigned SBITS     = salc_pkg::flog2(NSETS);
  localparam int unsigned HIBITS    = OBITS + SBITS;
  localparam int unsigned TBITS     = (ADDR_BITS > HIBITS) ? ADDR_BITS - HIBITS : 0;
  localparam int unsigned TAG_W     = (TBITS > 0) ? TBITS : 1;
  localparam int unsigned SET_W     = (SBITS > 0) ? SBITS : 1;
  localparam int unsigned SET_DEPTH = 1 << SBITS;
  localparam int unsigned AGE_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W     = WAYS * (TAG_W + 1 + AGE_W);
  localparam int unsigned W         = salc_pkg::WORD_W;

  localparam logic [W-1:0] ADDR_MASK =
    (ADDR_BITS >= W) ? {W{1'b1}} : ((W'(1) << ADDR_BITS) - W'(1));
  localparam logic [W-1:0] SET_MASK  = (W'(1) << SBITS) - W'(1);
  localparam logic [AGE_W-1:0] OLDEST = AGE_W'(WAYS - 1);

  // Set-row memory: all ways of one set in one word.
  logic [ROW_W-1:0] mem [SET_DEPTH];

  logic [ROW_W-1:0]  rd_row_r;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;
  logic [SET_W-1:0]  clr_cnt_r;
  logic              wbv_cfg_r;

  logic [salc_pkg::CNT_W-1:0] req_r, hit_cnt_r, miss_r, evc_r;

  logic                            out_valid_r;
  logic                            out_hit_r;
  logic [salc_pkg::OUT_WAY_W-1:0]  out_way_r;
  logic                            out_evicted_r;
  logic                            out_wbv_r;
  logic [salc_pkg::OUT_ADDR_W-1:0] out_wba_r;

  logic [W-1:0]     addr_in;
  logic [SET_W-1:0] set_in;
  logic [TAG_W-1:0] tag_in;

  logic [WAYS-1:0][TAG_W-1:0] rd_tags, nx_tags;
  logic [WAYS-1:0]            rd_val, nx_val;
  logic [WAYS-1:0][AGE_W-1:0] rd_age, nx_age, rst_age;

  logic             hit;
  logic [AGE_W-1:0] hit_way, vic_way, way_sel;
  logic [AGE_W-1:0] touched_age;
  logic             evicted;
  logic             wbv;
  logic [W-1:0]     wba;

  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;

  // Address split.
  assign addr_in = W'(in_address) & ADDR_MASK;
  assign set_in  = SET_W'((addr_in >> OBITS) & SET_MASK);
  assign tag_in  = TAG_W'(addr_in >> HIBITS);

  assign {rd_tags, rd_val, rd_age} = rd_row_r;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rst_age[i] = AGE_W'(i);
    end
  end

  // Tag compare and victim choice; lowest way wins both searches.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    vic_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rd_val[i] && (rd_tags[i] == tag_r)) begin
        hit     = 1'b1;
        hit_way = AGE_W'(i);
      end
      if (rd_age[i] == OLDEST) begin
        vic_way = AGE_W'(i);
      end
    end
  end

  assign way_sel     = hit ? hit_way : vic_way;
  assign touched_age = rd_age[way_sel];
  assign evicted     = !hit && rd_val[vic_way];
  assign wbv         = evicted && wbv_cfg_r;
  assign wba         = wbv ? ((W'(rd_tags[vic_way]) << HIBITS) | (W'(set_r) << OBITS))
                           : '0;

  // New row: replace on a miss, then true LRU aging around the touched way.
  always_comb begin
    nx_tags = rd_tags;
    nx_val  = rd_val;
    if (!hit) begin
      nx_tags[vic_way] = tag_r;
      nx_val[vic_way]  = 1'b1;
    end
    for (int i = 0; i < WAYS; i++) begin
      if (AGE_W'(i) == way_sel) begin
        nx_age[i] = '0;
      end else if (rd_age[i] < touched_age) begin
        nx_age[i] = rd_age[i] + AGE_W'(1);
      end else begin
        nx_age[i] = rd_age[i];
      end
    end
  end

  assign mem_we    = cmd.clr_en || cmd.update;
  assign mem_waddr = cmd.clr_en ? clr_cnt_r : set_r;
  assign mem_wdata = cmd.clr_en ? {{(WAYS * TAG_W){1'b0}}, {WAYS{1'b0}}, rst_age}
                                : {nx_tags, nx_val, nx_age};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_row_r <= mem[set_in];
      set_r    <= set_in;
      tag_r    <= tag_in;
    end
  end

  assign sts.clr_last = (clr_cnt_r == SET_W'(SET_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wbv_cfg_r <= 1'b1;
    end else if (cfg_we) begin
      wbv_cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r     <= '0;
      hit_cnt_r <= '0;
      miss_r    <= '0;
      evc_r     <= '0;
    end else if (cmd.update) begin
      req_r <= req_r + salc_pkg::CNT_W'(1);
      if (hit) begin
        hit_cnt_r <= hit_cnt_r + salc_pkg::CNT_W'(1);
      end else begin
        miss_r <= miss_r + salc_pkg::CNT_W'(1);
      end
      if (evicted) begin
        evc_r <= evc_r + salc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r     <= hit;
      out_way_r     <= salc_pkg::OUT_WAY_W'(way_sel);
      out_evicted_r <= evicted;
      out_wbv_r     <= wbv;
      out_wba_r     <= wba[salc_pkg::OUT_ADDR_W-1:0];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_hit               = out_hit_r;
  assign out_way               = out_way_r;
  assign out_evicted           = out_evicted_r;
  assign out_writeback_valid   = out_wbv_r;
  assign out_writeback_address = out_wba_r;
  assign out_request_count     = req_r;
  assign out_hit_count         = hit_cnt_r;
  assign out_miss_count        = miss_r;
  assign out_eviction_count    = evc_r;

endmodule

// File: design/set_assoc_lru_cache_tags.sv
// Top level of the set-associative cache tag array with true LRU replacement.
// Instantiates salc_ctrl and salc_dpath; depends on salc_pkg.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ----------------------------------
//   input     in_address                     accepted when start && !busy
//   result    out_hit ... out_eviction_count one cycle, marked by out_valid
//   config    cfg_wdata (writeback_victims)  written when cfg_we is high
//
// For each item, the accept edge reads the item's set row from the row
// memory, and the ST_LOOKUP state then compares tags, picks the victim,
// writes the row back and registers the result. The result strobe rises
// from those result registers, and busy is low again in the same cycle;
// a new item is taken only in ST_IDLE, after the previous one has left
// ST_LOOKUP. After reset a clearing sweep writes every set row, one per
// cycle, with busy high. The receiver cannot stall results.
module set_assoc_lru_cache_tags #(
  parameter int unsigned BLOCK_BYTES = salc_pkg::DEF_BLOCK_BYTES,
  parameter int unsigned CACHE_BYTES = salc_pkg::DEF_CACHE_BYTES,
  parameter int unsigned WAYS        = salc_pkg::DEF_WAYS,
  parameter int unsigned ADDR_BITS   = salc_pkg::DEF_ADDR_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [salc_pkg::IN_ADDR_W-1:0]    in_address,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [salc_pkg::OUT_WAY_W-1:0]    out_way,
  output logic                              out_evicted,
  output logic                              out_writeback_valid,
  output logic [salc_pkg::OUT_ADDR_W-1:0]   out_writeback_address,
  output logic [salc_pkg::CNT_W-1:0]        out_request_count,
  output logic [salc_pkg::CNT_W-1:0]        out_hit_count,
  output logic [salc_pkg::CNT_W-1:0]        out_miss_count,
  output logic [salc_pkg::CNT_W-1:0]        out_eviction_count
);

  // Command and status between the controller and the datapath.
  salc_pkg::salc_cmd_t cmd;
  salc_pkg::salc_sts_t sts;

  // The controller owns sequencing only: it runs the clearing sweep, takes an
  // item when idle and then runs the lookup and update in its ST_LOOKUP state.
  salc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the set rows, the counters, the writeback_victims
  // register and the result registers. The counters are shown directly on
  // the result ports; they change only at the edge that raises the strobe.
  salc_dpath #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .CACHE_BYTES (CACHE_BYTES),
    .WAYS        (WAYS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_address            (in_address),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .out_valid             (out_valid),
    .out_hit               (out_hit),
    .out_way               (out_way),
    .out_evicted           (out_evicted),
    .out_writeback_valid   (out_writeback_valid),
    .out_writeback_address (out_writeback_address),
    .out_request_count     (out_request_count),
    .out_hit_count         (out_hit_count),
    .out_miss_count        (out_miss_count),
    .out_eviction_count    (out_eviction_count)
  );

endmodule

// File: design/salc_chk.sv
// Port-level checker for the set-associative LRU cache tag block, bound to
// the top level. Depends on salc_pkg and set_assoc_lru_cache_tags.
module salc_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [salc_pkg::IN_ADDR_W-1:0]    in_address,
  input logic                              cfg_we,
  input logic                              cfg_wdata,
  input logic                              out_valid,
  input logic                              out_hit,
  input logic [salc_pkg::OUT_WAY_W-1:0]    out_way,
  input logic                              out_evicted,
  input logic                              out_writeback_valid,
  input logic [salc_pkg::OUT_ADDR_W-1:0]   out_writeback_address,
  input logic [salc_pkg::CNT_W-1:0]        out_request_count,
  input logic [salc_pkg::CNT_W-1:0]        out_hit_count,
  input logic [salc_pkg::CNT_W-1:0]        out_miss_count,
  input logic [salc_pkg::CNT_W-1:0]        out_eviction_count
);

  // Every accepted item yields a result marked by out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted item produced no result");

  // Each result advances the request count by exactly one.
  a_req_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_request_count == $past(out_request_count) + 64'd1))
    else $error("request count did not step by one");

  // Every request is either a hit or a miss.
  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit_count + out_miss_count == out_request_count))
    else $error("hit and miss counts do not add up");

  // A hit never evicts or reports a writeback.
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |->
      (!out_evicted && !out_writeback_valid && (out_writeback_address == '0)))
    else $error("hit reported an eviction");

  // A writeback is reported only for an eviction.
  a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_writeback_valid) |-> out_evicted)
    else $error("writeback without eviction");

endmodule

bind set_assoc_lru_cache_tags salc_chk u_salc_chk (.*);
